// ----- rtl/core/krd_pkg.sv -----
`default_nettype none

package krd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_SECS = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ARROW_MODE = 2'd0;
    localparam logic [1:0] CFG_RPT_FIRST  = 2'd1;
    localparam logic [1:0] CFG_RPT_NEXT   = 2'd2;

    // Reset values of the configuration registers
    localparam logic       RST_ARROW_MODE = 1'b0;
    localparam logic [7:0] RST_RPT_FIRST  = 8'd24;
    localparam logic [7:0] RST_RPT_NEXT   = 8'd4;

    // Key codes and characters
    localparam logic [6:0] KEY_PREFIX  = 7'h00;
    localparam logic [6:0] KEY_SHIFT   = 7'h7E;
    localparam logic [6:0] KEY_LOCK    = 7'h7D;
    localparam logic [6:0] KEY_COMMAND = 7'h7F;
    localparam logic [6:0] KEY_FIRST   = 7'h20;
    localparam logic [6:0] KEY_UP      = 7'h27;
    localparam logic [6:0] KEY_DN      = 7'h2B;
    localparam logic [6:0] KEY_RIGHT   = 7'h23;
    localparam logic [6:0] KEY_LEFT    = 7'h22;
    localparam logic [6:0] CH_ESC      = 7'h1B;
    localparam logic [6:0] CH_O        = 7'h4F;
    localparam logic [6:0] CH_BRACKET  = 7'h5B;
    localparam logic [3:0] CLK_PREFIX  = 4'hE;

    localparam int ROM_DEPTH = 96;

    // Unshifted key map, indexed by key code minus 0x20
    localparam logic [6:0] PLAIN_ROM [ROM_DEPTH] = '{
        7'h1B, 7'h2D, 7'h00, 7'h00, 7'h37, 7'h38, 7'h39, 7'h00,
        7'h34, 7'h35, 7'h36, 7'h00, 7'h2E, 7'h32, 7'h33, 7'h0A,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h2D, 7'h3D, 7'h5C, 7'h00, 7'h70, 7'h08, 7'h0A, 7'h00,
        7'h0D, 7'h30, 7'h00, 7'h00, 7'h2F, 7'h31, 7'h1B, 7'h00,
        7'h39, 7'h30, 7'h75, 7'h69, 7'h6A, 7'h6B, 7'h5B, 7'h5D,
        7'h6D, 7'h6C, 7'h3B, 7'h27, 7'h20, 7'h2C, 7'h2E, 7'h6F,
        7'h65, 7'h36, 7'h37, 7'h38, 7'h35, 7'h72, 7'h74, 7'h79,
        7'h60, 7'h66, 7'h67, 7'h68, 7'h76, 7'h63, 7'h62, 7'h6E,
        7'h61, 7'h32, 7'h33, 7'h34, 7'h31, 7'h71, 7'h73, 7'h77,
        7'h09, 7'h7A, 7'h78, 7'h64, 7'h1B, 7'h00, 7'h00, 7'h00
    };

    // Shifted key map
    localparam logic [6:0] SHIFT_ROM [ROM_DEPTH] = '{
        7'h7F, 7'h2D, 7'h2B, 7'h2A, 7'h37, 7'h38, 7'h39, 7'h2F,
        7'h34, 7'h35, 7'h36, 7'h2C, 7'h2E, 7'h32, 7'h33, 7'h0A,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h5F, 7'h2B, 7'h7C, 7'h00, 7'h50, 7'h08, 7'h0A, 7'h00,
        7'h0D, 7'h30, 7'h00, 7'h00, 7'h3F, 7'h31, 7'h1B, 7'h00,
        7'h28, 7'h29, 7'h55, 7'h49, 7'h4A, 7'h4B, 7'h7B, 7'h7D,
        7'h4D, 7'h4C, 7'h3A, 7'h22, 7'h20, 7'h3C, 7'h3E, 7'h4F,
        7'h45, 7'h5E, 7'h26, 7'h2A, 7'h25, 7'h52, 7'h54, 7'h59,
        7'h7E, 7'h46, 7'h47, 7'h48, 7'h56, 7'h43, 7'h42, 7'h4E,
        7'h41, 7'h40, 7'h23, 7'h24, 7'h21, 7'h51, 7'h53, 7'h57,
        7'h09, 7'h5A, 7'h58, 7'h44, 7'h1B, 7'h00, 7'h00, 7'h00
    };

    // Days from the epoch to 1 January of year 1980 + index
    localparam logic [13:0] YEAR_DAYS [16] = '{
        14'd3652, 14'd4018, 14'd4383, 14'd4748, 14'd5113, 14'd5479, 14'd5844, 14'd6209,
        14'd6574, 14'd6940, 14'd7305, 14'd7670, 14'd8035, 14'd8401, 14'd8766, 14'd9131
    };

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [6:0]  char_value;
        logic [30:0] clock_seconds;
        logic        last_of_run;
    } t_result;

    // Results of one input transaction
    typedef struct packed {
        logic [1:0]          cnt;
        t_result [2:0]       res;
    } t_group;

    typedef struct packed {
        logic       arrow_app_mode;
        logic [7:0] rpt_first_ticks;
        logic [7:0] rpt_next_ticks;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/core/krd_in_if.sv -----
`default_nettype none

interface krd_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] byte_value;

    modport source (output valid, output req_type, output byte_value, input ready);
    modport sink   (input valid, input req_type, input byte_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/krd_out_if.sv -----
`default_nettype none

interface krd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [6:0]  char_value;
    logic [30:0] clock_seconds;
    logic        last_of_run;

    modport source (output valid, output result_kind, output char_value,
                    output clock_seconds, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input char_value,
                    input clock_seconds, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/krd_cfg_if.sv -----
`default_nettype none

interface krd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/krd_decode.sv -----
`default_nettype none

module krd_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic            i_req_type,
    input  wire logic [7:0]      i_byte_value,
    input  wire krd_pkg::t_cfg   i_cfg,
    output krd_pkg::t_group      o_group
);

    localparam logic [2:0] PH_KEY     = 3'd0;
    localparam logic [2:0] PH_RESET   = 3'd1;
    localparam logic [2:0] PH_MOUSE_X = 3'd2;
    localparam logic [2:0] PH_MOUSE_Y = 3'd3;
    localparam logic [2:0] PH_CLOCK   = 3'd4;

    typedef struct packed {
        logic [1:0]       cnt;
        logic [2:0][6:0]  ch;
    } t_press;

    // Characters produced by one key press
    function automatic t_press f_press(input logic [6:0] code, input logic shift,
                                       input logic lock, input logic cmd,
                                       input logic app);
        t_press     p;
        logic [6:0] arrow;
        logic [6:0] c;
        logic [6:0] idx;
        p     = '0;
        arrow = '0;
        idx   = code - krd_pkg::KEY_FIRST;
        case (code)
            krd_pkg::KEY_UP:    arrow = 7'h41;
            krd_pkg::KEY_DN:    arrow = 7'h42;
            krd_pkg::KEY_RIGHT: arrow = 7'h43;
            krd_pkg::KEY_LEFT:  arrow = 7'h44;
            default:            arrow = '0;
        endcase
        if (code >= krd_pkg::KEY_FIRST) begin
            if (!shift && arrow != '0) begin
                p.cnt   = 2'd3;
                p.ch[0] = krd_pkg::CH_ESC;
                p.ch[1] = app ? krd_pkg::CH_O : krd_pkg::CH_BRACKET;
                p.ch[2] = arrow;
            end else begin
                c = shift ? krd_pkg::SHIFT_ROM[idx] : krd_pkg::PLAIN_ROM[idx];
                if (c != '0) begin
                    p.cnt = 2'd1;
                end
                if (lock && c >= 7'h61 && c <= 7'h7A) begin
                    c = c - 7'h20;
                end
                if (cmd) begin
                    c = c & 7'h1F;
                end
                p.ch[0] = c;
            end
        end
        return p;
    endfunction

    // Control state
    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_clk_left, n_clk_left;
    logic [3:0]  r_year, n_year;
    logic        r_shift, n_shift;
    logic        r_lock, n_lock;
    logic        r_cmd, n_cmd;
    logic [6:0]  r_rep_key, n_rep_key;
    logic [7:0]  r_rep_cd, n_rep_cd;

    // Clock reading accumulators
    logic [10:0] r_acc, n_acc;
    logic [7:0]  r_part, n_part;
    logic [29:0] r_t, n_t;
    logic        r_bad, n_bad;

    logic [6:0]  code;
    logic        down;
    logic [3:0]  hi, lo;
    logic [10:0] day;
    logic [7:0]  field;
    logic [13:0] days;
    logic        use_press;
    t_press      prs;

    assign code = i_byte_value[6:0];
    assign down = i_byte_value[7];
    assign hi   = i_byte_value[7:4];
    assign lo   = i_byte_value[3:0];
    assign day  = r_acc + 11'(hi);
    assign field = r_part + 8'(hi);
    assign days = krd_pkg::YEAR_DAYS[r_year] + 14'(day) - 14'd1;

    // One press unit serves both key bytes and repeat ticks
    assign prs = f_press(i_req_type ? r_rep_key : code, r_shift, r_lock, r_cmd,
                         i_cfg.arrow_app_mode);

    // Next state and results
    always_comb begin
        n_phase    = r_phase;
        n_clk_left = r_clk_left;
        n_year     = r_year;
        n_shift    = r_shift;
        n_lock     = r_lock;
        n_cmd      = r_cmd;
        n_rep_key  = r_rep_key;
        n_rep_cd   = r_rep_cd;
        n_acc      = r_acc;
        n_part     = r_part;
        n_t        = r_t;
        n_bad      = r_bad;
        use_press  = 1'b0;
        o_group    = '0;

        if (i_req_type) begin
            // timer tick: auto-repeat
            if (r_rep_key != '0) begin
                n_rep_cd = r_rep_cd - 8'd1;
                if (n_rep_cd == '0) begin
                    use_press = 1'b1;
                    n_rep_cd  = i_cfg.rpt_next_ticks;
                end
            end
        end else begin
            case (r_phase)
                PH_RESET: begin
                    n_phase   = PH_KEY;
                    n_shift   = 1'b0;
                    n_cmd     = 1'b0;
                    n_rep_key = '0;
                    if (hi == krd_pkg::CLK_PREFIX) begin
                        n_phase    = PH_CLOCK;
                        n_clk_left = 3'd5;
                        n_year     = lo;
                    end
                end
                PH_MOUSE_X: n_phase = PH_MOUSE_Y;
                PH_MOUSE_Y: n_phase = PH_KEY;
                PH_CLOCK: begin
                    n_clk_left = r_clk_left - 3'd1;
                    case (r_clk_left)
                        3'd5: begin
                            n_acc = 11'(hi) * 11'd100 + 11'(lo) * 11'd10;
                            n_bad = 1'b0;
                        end
                        3'd4: begin
                            n_bad  = r_bad || day == '0 || day > 11'd366;
                            n_t    = 30'(days) * 30'd24;
                            n_part = 8'(lo) * 8'd10;
                        end
                        3'd3: begin
                            n_bad  = r_bad || field > 8'd23;
                            n_t    = (r_t + 30'(field)) * 30'd60;
                            n_part = 8'(lo) * 8'd10;
                        end
                        3'd2: begin
                            n_bad  = r_bad || field > 8'd59;
                            n_t    = (r_t + 30'(field)) * 30'd60;
                            n_part = 8'(lo) * 8'd10;
                        end
                        3'd1: begin
                            n_bad  = r_bad || field > 8'd59;
                            n_t    = r_t + 30'(field);
                            o_group.cnt = 2'd1;
                            o_group.res[0].last_of_run = 1'b1;
                            if (n_bad) begin
                                o_group.res[0].result_kind = krd_pkg::KIND_BAD;
                            end else begin
                                o_group.res[0].result_kind   = krd_pkg::KIND_SECS;
                                o_group.res[0].clock_seconds = 31'(n_t);
                            end
                        end
                        default: ;
                    endcase
                    if (n_clk_left == '0) begin
                        n_phase = PH_KEY;
                    end
                end
                default: begin
                    // key transitions and prefixes
                    if (code == krd_pkg::KEY_PREFIX) begin
                        n_phase = down ? PH_RESET : PH_MOUSE_X;
                    end else if (code == krd_pkg::KEY_SHIFT) begin
                        n_shift = down;
                    end else if (code == krd_pkg::KEY_LOCK) begin
                        n_lock = down;
                    end else if (code == krd_pkg::KEY_COMMAND) begin
                        n_cmd = down;
                    end else if (down) begin
                        use_press = 1'b1;
                        if (code >= krd_pkg::KEY_FIRST) begin
                            n_rep_key = code;
                            n_rep_cd  = i_cfg.rpt_first_ticks;
                        end
                    end else if (code == r_rep_key) begin
                        n_rep_key = '0;
                    end
                end
            endcase
        end

        // character results
        if (use_press) begin
            o_group.cnt = prs.cnt;
            for (int k = 0; k < 3; k++) begin
                o_group.res[k].result_kind = krd_pkg::KIND_CHAR;
                o_group.res[k].char_value  = prs.ch[k];
                o_group.res[k].last_of_run = (2'(k) == prs.cnt - 2'd1);
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_KEY;
            r_clk_left <= '0;
            r_year     <= '0;
            r_shift    <= 1'b0;
            r_lock     <= 1'b0;
            r_cmd      <= 1'b0;
            r_rep_key  <= '0;
            r_rep_cd   <= '0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_clk_left <= n_clk_left;
            r_year     <= n_year;
            r_shift    <= n_shift;
            r_lock     <= n_lock;
            r_cmd      <= n_cmd;
            r_rep_key  <= n_rep_key;
            r_rep_cd   <= n_rep_cd;
        end
    end

    // Clock reading accumulators
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_acc  <= n_acc;
            r_part <= n_part;
            r_t    <= n_t;
            r_bad  <= n_bad;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/krd_result_q.sv -----
`default_nettype none

module krd_result_q (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire krd_pkg::t_group i_group,
    output logic                 o_free,
    krd_out_if.source            o_out
);

    krd_pkg::t_result r_mem [4];
    logic [1:0]       r_rd;
    logic [1:0]       r_wr;
    logic [2:0]       r_cnt;
    logic             pop;
    logic [1:0]       push_cnt;

    // Room for a full group of three, decided from registered state only
    assign o_free   = r_cnt <= 3'd1;
    assign pop      = r_cnt != '0 && o_out.ready;
    assign push_cnt = i_load ? i_group.cnt : 2'd0;

    assign o_out.valid         = r_cnt != '0;
    assign o_out.result_kind   = r_mem[r_rd].result_kind;
    assign o_out.char_value    = r_mem[r_rd].char_value;
    assign o_out.clock_seconds = r_mem[r_rd].clock_seconds;
    assign o_out.last_of_run   = r_mem[r_rd].last_of_run;

    // Result storage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < push_cnt) begin
                r_mem[r_wr + 2'(k)] <= i_group.res[k];
            end
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + push_cnt;
            r_rd  <= r_rd + 2'(pop);
            r_cnt <= r_cnt + 3'(push_cnt) - 3'(pop);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/keyboard_report_decoder.sv -----
// Keyboard report decoder.
// i_in carries one transaction per controller byte (req_type 0) or timer tick
// (req_type 1). o_out returns the result transactions: characters, clock
// seconds or a bad clock flag; last_of_run marks the final result of an input.
// i_cfg writes the configuration registers (0 arrow mode, 1 repeat delay,
// 2 repeat rate); it is always ready and should be written while idle.
// An accepted input waits in the input register until the queue has room,
// is then decoded, and its results are written into the result queue, from
// which they are presented in order.
// Throughput: one input per cycle while each gives at most one result and
// the receiver is ready; an arrow key gives three results, which leave one
// per cycle through the single result read port while the input stalls.
// A four-entry result queue separates the sides: input is taken as long as
// the queue holds at most one result, so a stalled receiver backs up into
// the input register and then drops i_in.ready without losing anything.
// Reset (synchronous, active low) clears the modifiers, repeat state, stream
// phase and queue and restores the register defaults; no clearing pass.
`default_nettype none

module keyboard_report_decoder (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    krd_in_if.sink     i_in,
    krd_out_if.source  o_out,
    krd_cfg_if.sink    i_cfg
);

    logic            r_in_vld;
    logic            r_req_type;
    logic [7:0]      r_byte_value;
    logic            dec_take;
    logic            q_free;
    krd_pkg::t_cfg   r_cfg;
    krd_pkg::t_group group;

    // Input register
    assign dec_take   = r_in_vld && q_free;
    assign i_in.ready = !r_in_vld || dec_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (dec_take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req_type   <= i_in.req_type;
            r_byte_value <= i_in.byte_value;
        end
    end

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arrow_app_mode  <= krd_pkg::RST_ARROW_MODE;
            r_cfg.rpt_first_ticks <= krd_pkg::RST_RPT_FIRST;
            r_cfg.rpt_next_ticks  <= krd_pkg::RST_RPT_NEXT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                krd_pkg::CFG_ARROW_MODE: r_cfg.arrow_app_mode  <= i_cfg.data[0];
                krd_pkg::CFG_RPT_FIRST:  r_cfg.rpt_first_ticks <= i_cfg.data;
                krd_pkg::CFG_RPT_NEXT:   r_cfg.rpt_next_ticks  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    krd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (dec_take),
        .i_req_type   (r_req_type),
        .i_byte_value (r_byte_value),
        .i_cfg        (r_cfg),
        .o_group      (group)
    );

    krd_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (dec_take),
        .i_group (group),
        .o_free  (q_free),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- verif/keyboard_report_decoder_tb.sv -----
module keyboard_report_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_CYCLES  = 8;
    localparam int CLOCK_LEN    = 5;
    localparam int EPOCH_YEAR   = 1970;
    localparam int BASE_YEAR    = 1980;

    localparam logic [6:0] CTRL_MASK   = 7'h1F;
    localparam logic [6:0] CASE_OFFSET = 7'h20;
    localparam logic [6:0] KEY_A       = 7'h70;

    localparam logic [6:0] ARROW_KEYS [4] = '{krd_pkg::KEY_UP, krd_pkg::KEY_DN,
                                             krd_pkg::KEY_RIGHT, krd_pkg::KEY_LEFT};

    // Key maps, indexed by key code minus 0x20
    localparam logic [6:0] KEYMAP_PLAIN [96] = '{
        7'h1B, 7'h2D, 7'h00, 7'h00, 7'h37, 7'h38, 7'h39, 7'h00, 7'h34, 7'h35, 7'h36, 7'h00,
        7'h2E, 7'h32, 7'h33, 7'h0A, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h2D, 7'h3D, 7'h5C, 7'h00,
        7'h70, 7'h08, 7'h0A, 7'h00, 7'h0D, 7'h30, 7'h00, 7'h00, 7'h2F, 7'h31, 7'h1B, 7'h00,
        7'h39, 7'h30, 7'h75, 7'h69, 7'h6A, 7'h6B, 7'h5B, 7'h5D, 7'h6D, 7'h6C, 7'h3B, 7'h27,
        7'h20, 7'h2C, 7'h2E, 7'h6F, 7'h65, 7'h36, 7'h37, 7'h38, 7'h35, 7'h72, 7'h74, 7'h79,
        7'h60, 7'h66, 7'h67, 7'h68, 7'h76, 7'h63, 7'h62, 7'h6E, 7'h61, 7'h32, 7'h33, 7'h34,
        7'h31, 7'h71, 7'h73, 7'h77, 7'h09, 7'h7A, 7'h78, 7'h64, 7'h1B, 7'h00, 7'h00, 7'h00
    };

    localparam logic [6:0] KEYMAP_SHIFTED [96] = '{
        7'h7F, 7'h2D, 7'h2B, 7'h2A, 7'h37, 7'h38, 7'h39, 7'h2F, 7'h34, 7'h35, 7'h36, 7'h2C,
        7'h2E, 7'h32, 7'h33, 7'h0A, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h5F, 7'h2B, 7'h7C, 7'h00,
        7'h50, 7'h08, 7'h0A, 7'h00, 7'h0D, 7'h30, 7'h00, 7'h00, 7'h3F, 7'h31, 7'h1B, 7'h00,
        7'h28, 7'h29, 7'h55, 7'h49, 7'h4A, 7'h4B, 7'h7B, 7'h7D, 7'h4D, 7'h4C, 7'h3A, 7'h22,
        7'h20, 7'h3C, 7'h3E, 7'h4F, 7'h45, 7'h5E, 7'h26, 7'h2A, 7'h25, 7'h52, 7'h54, 7'h59,
        7'h7E, 7'h46, 7'h47, 7'h48, 7'h56, 7'h43, 7'h42, 7'h4E, 7'h41, 7'h40, 7'h23, 7'h24,
        7'h21, 7'h51, 7'h53, 7'h57, 7'h09, 7'h5A, 7'h58, 7'h44, 7'h1B, 7'h00, 7'h00, 7'h00
    };

    typedef enum logic [2:0] {
        STREAM_KEY, STREAM_RESET_CODE, STREAM_MOUSE_X, STREAM_MOUSE_Y, STREAM_CLOCK
    } t_stream;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_LONG} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    krd_in_if  in_bus();
    krd_out_if out_bus();
    krd_cfg_if cfg_bus();

    keyboard_report_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always #4 i_clk = ~i_clk;

    // Decoder state mirror
    logic       arrow_app  = krd_pkg::RST_ARROW_MODE;
    logic [7:0] rpt_delay  = krd_pkg::RST_RPT_FIRST;
    logic [7:0] rpt_rate   = krd_pkg::RST_RPT_NEXT;
    t_stream    phase      = STREAM_KEY;
    logic [2:0] clk_left   = '0;
    logic [3:0] clk_year   = '0;
    logic [7:0] clk_bytes [CLOCK_LEN];
    logic       shift_dn   = 1'b0;
    logic       lock_dn    = 1'b0;
    logic       cmd_dn     = 1'b0;
    logic [6:0] rpt_key    = '0;
    logic [7:0] rpt_count  = '0;

    krd_pkg::t_result expected_results [$];
    krd_pkg::t_result run_results [$];
    krd_pkg::t_result want_r;

    int errors          = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int cfg_writes      = 0;
    int burst_left      = 0;
    int cycles          = 0;
    int rx_left         = 0;
    t_rx_mode rx_mode   = RX_OPEN;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40) begin
            $display("%0t ns: result %0d: %s", $time, results_checked, msg);
        end
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [6:0] ch,
                               input logic [30:0] secs);
        krd_pkg::t_result r;
        r.result_kind   = kind;
        r.char_value    = ch;
        r.clock_seconds = secs;
        r.last_of_run   = 1'b0;
        run_results.push_back(r);
    endtask

    // Characters for one key press with the current modifiers
    task automatic key_chars(input logic [6:0] code);
        logic [6:0] c;
        c = '0;
        if (code < krd_pkg::KEY_FIRST) return;
        if (!shift_dn) begin
            case (code)
                krd_pkg::KEY_UP:    c = 7'("A");
                krd_pkg::KEY_DN:    c = 7'("B");
                krd_pkg::KEY_RIGHT: c = 7'("C");
                krd_pkg::KEY_LEFT:  c = 7'("D");
                default:            c = '0;
            endcase
            if (c != 0) begin
                push_result(krd_pkg::KIND_CHAR, krd_pkg::CH_ESC, '0);
                push_result(krd_pkg::KIND_CHAR,
                            arrow_app ? krd_pkg::CH_O : krd_pkg::CH_BRACKET, '0);
                push_result(krd_pkg::KIND_CHAR, c, '0);
                return;
            end
        end
        c = shift_dn ? KEYMAP_SHIFTED[code - krd_pkg::KEY_FIRST]
                     : KEYMAP_PLAIN[code - krd_pkg::KEY_FIRST];
        if (c == 0) return;
        if (lock_dn && c >= 7'("a") && c <= 7'("z")) c = c - CASE_OFFSET;
        if (cmd_dn) c = c & CTRL_MASK;
        push_result(krd_pkg::KIND_CHAR, c, '0);
    endtask

    // BCD reading to seconds since the epoch
    task automatic clock_result();
        int unsigned dd, hh, mm, ss, days;
        dd = clk_bytes[0][7:4] * 100 + clk_bytes[0][3:0] * 10 + clk_bytes[1][7:4];
        hh = clk_bytes[1][3:0] * 10 + clk_bytes[2][7:4];
        mm = clk_bytes[2][3:0] * 10 + clk_bytes[3][7:4];
        ss = clk_bytes[3][3:0] * 10 + clk_bytes[4][7:4];
        if (dd < 1 || dd > 366 || hh > 23 || mm > 59 || ss > 59) begin
            push_result(krd_pkg::KIND_BAD, '0, '0);
            return;
        end
        days = 0;
        for (int y = EPOCH_YEAR; y < BASE_YEAR + clk_year; y++) begin
            days += (y % 4 == 0) ? 366 : 365;
        end
        days = days + dd - 1;
        push_result(krd_pkg::KIND_SECS, '0, 31'(((days * 24 + hh) * 60 + mm) * 60 + ss));
    endtask

    task automatic take_byte(input logic [7:0] b);
        logic [6:0] code;
        logic       down;
        code = b[6:0];
        down = b[7];
        case (phase)
            STREAM_RESET_CODE: begin
                phase = STREAM_KEY;
                if (b[7:4] == krd_pkg::CLK_PREFIX) begin
                    phase    = STREAM_CLOCK;
                    clk_left = 3'(CLOCK_LEN);
                    clk_year = b[3:0];
                end
                shift_dn = 1'b0;
                cmd_dn   = 1'b0;
                rpt_key  = '0;
            end
            STREAM_MOUSE_X: phase = STREAM_MOUSE_Y;
            STREAM_MOUSE_Y: phase = STREAM_KEY;
            STREAM_CLOCK: begin
                clk_bytes[CLOCK_LEN - clk_left] = b;
                clk_left = clk_left - 3'd1;
                if (clk_left == 0) begin
                    phase = STREAM_KEY;
                    clock_result();
                end
            end
            default: begin
                if (code == krd_pkg::KEY_PREFIX)
                    phase = down ? STREAM_RESET_CODE : STREAM_MOUSE_X;
                else if (code == krd_pkg::KEY_SHIFT) shift_dn = down;
                else if (code == krd_pkg::KEY_LOCK) lock_dn = down;
                else if (code == krd_pkg::KEY_COMMAND) cmd_dn = down;
                else if (down) begin
                    key_chars(code);
                    if (code >= krd_pkg::KEY_FIRST) begin
                        rpt_key   = code;
                        rpt_count = rpt_delay;
                    end
                end else if (code == rpt_key) rpt_key = '0;
            end
        endcase
    endtask

    // Expected results of one accepted input transaction
    task automatic decode_input(input logic typ, input logic [7:0] b);
        run_results = {};
        if (typ == REQ_TICK) begin
            if (rpt_key != 0) begin
                rpt_count = rpt_count - 8'd1;
                if (rpt_count == 0) begin
                    key_chars(rpt_key);
                    rpt_count = rpt_rate;
                end
            end
        end else begin
            take_byte(b);
        end
        if (run_results.size() > 0) run_results[run_results.size() - 1].last_of_run = 1'b1;
        foreach (run_results[i]) expected_results.push_back(run_results[i]);
    endtask

    // Sender: bursts with random gaps; valid stays high inside a burst
    task automatic send_item(input logic typ, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_bus.valid      <= 1'b1;
        in_bus.req_type   <= typ;
        in_bus.byte_value <= b;
        do @(posedge i_clk); while (!in_bus.ready);
        decode_input(typ, b);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(REQ_BYTE, b);
    endtask

    task automatic send_tick();
        send_item(REQ_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            krd_pkg::CFG_ARROW_MODE: arrow_app = data[0];
            krd_pkg::CFG_RPT_FIRST:  rpt_delay = data;
            krd_pkg::CFG_RPT_NEXT:   rpt_rate  = data;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
    endtask

    // Registers change only once the decoder has gone quiet
    task automatic set_config(input logic mode, input logic [7:0] dly, input logic [7:0] rate);
        in_bus.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (IDLE_CYCLES) @(negedge i_clk);
        write_reg(krd_pkg::CFG_ARROW_MODE, {7'd0, mode});
        write_reg(krd_pkg::CFG_RPT_FIRST, dly);
        write_reg(krd_pkg::CFG_RPT_NEXT, rate);
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly well-formed key and clock traffic, some prefixes and noise
    task automatic random_traffic(input int n);
        int target, pick, nt, dd, hh, mm, ss;
        logic [6:0] code;
        logic [7:0] rd [CLOCK_LEN];
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // key tap with ticks while held
                code = ($urandom_range(0, 4) == 0) ? ARROW_KEYS[$urandom_range(0, 3)]
                                                    : 7'($urandom_range(1, 127));
                send_byte({1'b1, code});
                nt = $urandom_range(0, 10);
                repeat (nt) send_tick();
                if ($urandom_range(0, 5) != 0) send_byte({1'b0, code});
            end else if (pick < 55) begin
                case ($urandom_range(0, 2))
                    0:       code = krd_pkg::KEY_SHIFT;
                    1:       code = krd_pkg::KEY_LOCK;
                    default: code = krd_pkg::KEY_COMMAND;
                endcase
                send_byte({1'($urandom_range(0, 1)), code});
            end else if (pick < 65) begin
                nt = $urandom_range(1, 10);
                repeat (nt) send_tick();
            end else if (pick < 75) begin
                // clock reading: reset prefix, year code, five BCD bytes
                if ($urandom_range(0, 4) != 0) begin
                    dd = ($urandom_range(0, 3) == 0) ? 366 : $urandom_range(1, 366);
                    hh = ($urandom_range(0, 3) == 0) ? 23 : $urandom_range(0, 23);
                    mm = ($urandom_range(0, 3) == 0) ? 59 : $urandom_range(0, 59);
                    ss = ($urandom_range(0, 3) == 0) ? 59 : $urandom_range(0, 59);
                    rd[0] = {4'(dd / 100), 4'((dd / 10) % 10)};
                    rd[1] = {4'(dd % 10), 4'(hh / 10)};
                    rd[2] = {4'(hh % 10), 4'(mm / 10)};
                    rd[3] = {4'(mm % 10), 4'(ss / 10)};
                    rd[4] = {4'(ss % 10), 4'($urandom_range(0, 15))};
                end else begin
                    foreach (rd[i]) rd[i] = 8'($urandom_range(0, 255));
                end
                send_byte({1'b1, krd_pkg::KEY_PREFIX});
                send_byte({krd_pkg::CLK_PREFIX, 4'($urandom_range(0, 15))});
                foreach (rd[i]) send_byte(rd[i]);
            end else if (pick < 82) begin
                send_byte({1'b0, krd_pkg::KEY_PREFIX});
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 89) begin
                send_byte({1'b1, krd_pkg::KEY_PREFIX});
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Key maps, modifiers, arrows, codes with no character, one tick
    task automatic test_key_decoding();
        send_byte({1'b1, KEY_A});
        send_byte({1'b1, krd_pkg::KEY_LOCK});
        send_byte({1'b1, KEY_A});                  // caps lock upper-cases letters
        send_byte({1'b1, krd_pkg::KEY_COMMAND});
        send_byte({1'b1, KEY_A});                  // control masking
        send_byte({1'b0, krd_pkg::KEY_COMMAND});
        send_byte({1'b0, krd_pkg::KEY_LOCK});
        send_byte({1'b1, krd_pkg::KEY_SHIFT});
        send_byte({1'b1, krd_pkg::KEY_UP});        // shifted arrow gives a plain character
        send_byte({1'b0, krd_pkg::KEY_SHIFT});
        send_byte({1'b1, krd_pkg::KEY_UP});        // escape sequence
        send_byte(8'h85);                          // low code: no character
        send_byte(8'hB0);                          // key with an empty map entry
        send_tick();
    endtask

    // Reset code clears shift; mouse report bytes are swallowed
    task automatic test_prefixes();
        send_byte({1'b1, krd_pkg::KEY_SHIFT});
        send_byte({1'b1, krd_pkg::KEY_PREFIX});
        send_byte(8'h12);
        send_byte({1'b1, krd_pkg::KEY_LEFT});
        send_byte({1'b0, krd_pkg::KEY_PREFIX});
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    // Latest valid reading: last year, day 366, 23:59:59
    task automatic test_clock_reading();
        send_byte({1'b1, krd_pkg::KEY_PREFIX});
        send_byte({krd_pkg::CLK_PREFIX, 4'hF});
        send_byte(8'h36);
        send_byte(8'h62);
        send_byte(8'h35);
        send_byte(8'h95);
        send_byte(8'h97);
    endtask

    task automatic test_random_defaults();
        random_traffic(60);
    endtask

    // Arrow modes and repeat timing across several register settings
    task automatic test_register_settings();
        set_config(1'b1, 8'd1, 8'd1);
        random_traffic(70);
        set_config(1'b0, 8'd255, 8'd255);
        random_traffic(50);
        set_config(1'b1, 8'd3, 8'd2);
        random_traffic(70);
        set_config(1'($urandom_range(0, 1)), 8'($urandom_range(1, 12)),
                   8'($urandom_range(1, 12)));
        random_traffic(75);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction kind %0d char %h secs %0d",
                                out_bus.result_kind, out_bus.char_value,
                                out_bus.clock_seconds));
            end else begin
                want_r = expected_results.pop_front();
                if (out_bus.result_kind !== want_r.result_kind)
                    report_mismatch($sformatf("result_kind %0d, want %0d",
                                    out_bus.result_kind, want_r.result_kind));
                if (out_bus.char_value !== want_r.char_value)
                    report_mismatch($sformatf("char_value %h, want %h",
                                    out_bus.char_value, want_r.char_value));
                if (out_bus.clock_seconds !== want_r.clock_seconds)
                    report_mismatch($sformatf("clock_seconds %0d, want %0d",
                                    out_bus.clock_seconds, want_r.clock_seconds));
                if (out_bus.last_of_run !== want_r.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                    out_bus.last_of_run, want_r.last_of_run));
                results_checked++;
            end
        end
    end

    // Receiver stall pattern, picking a new random mode after each run
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(8, 40);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   out_bus.ready <= 1'b1;
                RX_RANDOM: out_bus.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_bus.ready <= (rx_left % 4 == 0);
                default:   out_bus.ready <= (rx_left % 12 == 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("keyboard_report_decoder: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.req_type   = REQ_BYTE;
        in_bus.byte_value = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = krd_pkg::CFG_ARROW_MODE;
        cfg_bus.data      = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_key_decoding();
        test_prefixes();
        test_clock_reading();
        test_random_defaults();
        test_register_settings();

        // drain
        in_bus.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d input transactions, %0d results checked, %0d register writes",
                 items_sent, results_checked, cfg_writes);
        $display("covered key maps, modifiers, arrows, auto-repeat, clock readings, prefixes");
        if (errors == 0) begin
            $display("keyboard_report_decoder: match");
        end else begin
            $display("keyboard_report_decoder: mismatch");
        end
        $finish;
    end

endmodule

// ----- keyboard_report_decoder.f -----
rtl/core/krd_pkg.sv
rtl/core/krd_in_if.sv
rtl/core/krd_out_if.sv
rtl/core/krd_cfg_if.sv
rtl/core/krd_decode.sv
rtl/core/krd_result_q.sv
rtl/core/keyboard_report_decoder.sv
verif/keyboard_report_decoder_tb.sv
